// ===== design/cou_pkg.sv =====
`default_nettype none

package cou_pkg;

    // number formats
    localparam int ANGLE_FRAC_BITS  = 8;
    localparam int VECTOR_FRAC_BITS = 14;
    localparam int SENS_FRAC_BITS   = 10;
    localparam int ZFRAC            = 24;
    localparam int XFRAC            = 30;
    localparam int TABLE_LEN        = 24;

    localparam logic [9:0] SENS_RESET = 10'd102;

    // cordic start value, reciprocal of the gain at 30 fractional bits
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    typedef logic signed [31:0] xval_t;
    typedef logic signed [32:0] zval_t;
    typedef logic signed [15:0] vcomp_t;

    // arctan(2^-i) in degrees, 24 fractional bits
    localparam zval_t ATAN_DEG [0:TABLE_LEN-1] = '{
        33'sd754974720, 33'sd445687602, 33'sd235489088, 33'sd119537938,
        33'sd60000934,  33'sd30029717,  33'sd15018523,  33'sd7509720,
        33'sd3754917,   33'sd1877466,   33'sd938734,    33'sd469367,
        33'sd234684,    33'sd117342,    33'sd58671,     33'sd29335,
        33'sd14668,     33'sd7334,      33'sd3667,      33'sd1833,
        33'sd917,       33'sd458,       33'sd229,       33'sd115
    };

    // what one cordic cell hands to the next
    typedef struct packed {
        xval_t x;
        xval_t y;
        zval_t z;
        logic  neg;
        logic  is_pitch;
    } cord_t;

    // basis vector components
    typedef struct packed {
        vcomp_t front_x;
        vcomp_t front_y;
        vcomp_t front_z;
        vcomp_t right_x;
        vcomp_t right_z;
        vcomp_t up_x;
        vcomp_t up_y;
        vcomp_t up_z;
    } vec_t;

endpackage

`default_nettype wire

// ===== design/cou_cell.sv =====
`default_nettype none

module cou_cell #(
    parameter int STEP = 0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire cou_pkg::cord_t in_data,
    output logic               out_valid,
    output cou_pkg::cord_t     out_data
);

    logic           valid_reg;
    cou_pkg::cord_t data_reg;
    cou_pkg::cord_t data_next;

    // one micro-rotation towards z = 0
    always_comb
    begin
        data_next = in_data;
        if (!in_data.z[32])
        begin
            data_next.x = in_data.x - (in_data.y >>> STEP);
            data_next.y = in_data.y + (in_data.x >>> STEP);
            data_next.z = in_data.z - cou_pkg::ATAN_DEG[STEP];
        end
        else
        begin
            data_next.x = in_data.x + (in_data.y >>> STEP);
            data_next.y = in_data.y - (in_data.x >>> STEP);
            data_next.z = in_data.z + cou_pkg::ATAN_DEG[STEP];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== design/cou_vec.sv =====
`default_nettype none

module cou_vec (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire cou_pkg::xval_t        cy,
    input  wire cou_pkg::xval_t        sy,
    input  wire cou_pkg::xval_t        cp,
    input  wire cou_pkg::xval_t        sp,
    output logic                       done,
    output cou_pkg::vec_t              vec
);

    localparam int SFT_S = cou_pkg::XFRAC - cou_pkg::VECTOR_FRAC_BITS;
    localparam int SFT_P = 2 * cou_pkg::XFRAC - cou_pkg::VECTOR_FRAC_BITS;
    localparam logic signed [63:0] ONE = 64'sd1 <<< cou_pkg::VECTOR_FRAC_BITS;

    typedef enum logic [1:0] {
        PROD_FRONT_X = 2'd0,
        PROD_FRONT_Z = 2'd1,
        PROD_UP_X    = 2'd2,
        PROD_UP_Z    = 2'd3
    } prod_sel_t;

    function automatic cou_pkg::vcomp_t sat_unit(input logic signed [63:0] v);
        cou_pkg::vcomp_t r;
        if (v > ONE)
            r = 16'(ONE);
        else if (v < -ONE)
            r = 16'(-ONE);
        else
            r = 16'(v);
        return r;
    endfunction

    function automatic cou_pkg::vcomp_t round_single(input logic signed [32:0] v);
        logic signed [33:0] t;
        t = 34'(v) + (34'sd1 <<< (SFT_S - 1));
        return sat_unit(64'(t >>> SFT_S));
    endfunction

    function automatic cou_pkg::vcomp_t round_prod(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + (64'sd1 <<< (SFT_P - 1));
        return sat_unit(t >>> SFT_P);
    endfunction

    logic               busy_reg;
    prod_sel_t          sel_reg;
    logic               prod_valid_reg;
    prod_sel_t          prod_sel_reg;
    logic signed [63:0] prod_reg;
    logic               done_reg;
    cou_pkg::vec_t      vec_reg;

    cou_pkg::xval_t     mul_a;
    cou_pkg::xval_t     mul_b;
    logic signed [63:0] prod_next;
    cou_pkg::vcomp_t    rnd;

    // one shared multiplier, four products in turn
    always_comb
    begin
        case (sel_reg)
            PROD_FRONT_X:
            begin
                mul_a = cy;
                mul_b = cp;
            end
            PROD_FRONT_Z:
            begin
                mul_a = sy;
                mul_b = cp;
            end
            PROD_UP_X:
            begin
                mul_a = cy;
                mul_b = sp;
            end
            PROD_UP_Z:
            begin
                mul_a = sy;
                mul_b = sp;
            end
            default:
            begin
                mul_a = cy;
                mul_b = cp;
            end
        endcase
        prod_next = mul_a * mul_b;
        rnd       = round_prod(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            sel_reg        <= PROD_FRONT_X;
            prod_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= busy_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                sel_reg  <= PROD_FRONT_X;
            end
            else if (busy_reg)
            begin
                if (sel_reg == PROD_UP_Z)
                    busy_reg <= 1'b0;
                sel_reg <= prod_sel_t'(sel_reg + 2'd1);
            end
            done_reg <= prod_valid_reg && (prod_sel_reg == PROD_UP_Z);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        prod_sel_reg <= sel_reg;
        if (start)
        begin
            vec_reg.front_y <= round_single(33'(sp));
            vec_reg.right_x <= round_single(-33'(sy));
            vec_reg.right_z <= round_single(33'(cy));
            vec_reg.up_y    <= round_single(33'(cp));
        end
        if (prod_valid_reg)
        begin
            case (prod_sel_reg)
                PROD_FRONT_X: vec_reg.front_x <= rnd;
                PROD_FRONT_Z: vec_reg.front_z <= rnd;
                PROD_UP_X:    vec_reg.up_x    <= -rnd;
                PROD_UP_Z:    vec_reg.up_z    <= -rnd;
                default:      vec_reg.front_x <= rnd;
            endcase
        end
    end

    assign done = done_reg;
    assign vec  = vec_reg;

endmodule

`default_nettype wire

// ===== design/camera_orientation_update.sv =====
`default_nettype none

// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tdata: delta_x, delta_y
// m_axis    out  m_axis_tvalid/tready    tdata: yaw, pitch, front, right, up
// cfg       in   cfg_wr_en               cfg_wr_data: sensitivity
//
// path: yaw and then pitch pass through the cordic chain, one cell per cycle, and the
// shared multiplier then forms the four products in turn before the result is loaded
// into the output register
// stalls: s_axis_tready is high only while idle; once the result is loaded into the
// output register the next item is taken, even while m_axis_tready is low
// reset (asynchronous, active low): yaw -90 degrees, pitch 0, sensitivity 102

module camera_orientation_update #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // slave side
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [23:0]  s_axis_tdata,   // delta_x[9:0], delta_y[19:10], zeros
    // master side
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [167:0]      m_axis_tdata,   // yaw_angle[17:0], pitch_angle[33:18],
                                              // front_x, front_y, front_z, right_x,
                                              // right_z, up_x, up_y, up_z (16 each),
                                              // zeros[167:162]
    // sensitivity register
    input  wire logic         cfg_wr_en,
    input  wire logic [9:0]   cfg_wr_data
);

    localparam int AFB    = cou_pkg::ANGLE_FRAC_BITS;
    localparam int SFB    = cou_pkg::SENS_FRAC_BITS;
    localparam int SCW    = 20 + AFB + 1;
    localparam int SHIFTZ = cou_pkg::ZFRAC - AFB;

    // angle limits in 1/256 degree
    localparam logic signed [19:0] FULL_ANG     = 20'(360 * (1 << AFB));
    localparam logic signed [19:0] TWO_FULL_ANG = 20'(720 * (1 << AFB));
    localparam logic signed [19:0] HALF_ANG     = 20'(180 * (1 << AFB));
    localparam logic signed [19:0] QUARTER_ANG  = 20'(90 * (1 << AFB));
    localparam logic signed [19:0] PITCH_LIM    = 20'(89 * (1 << AFB));

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_UPDATE,
        S_FEED_YAW,
        S_FEED_PITCH,
        S_WAIT,
        S_VEC_GO,
        S_VEC_WAIT,
        S_OUT
    } state_t;

    // delta times sensitivity, rescaled to the angle unit, rounded half away from zero
    function automatic logic signed [17:0] scale_step(input logic signed [9:0] d,
                                                      input logic [9:0] sens);
        logic signed [20:0] p;
        logic [19:0]        mag;
        logic [SCW-1:0]     sc;
        logic [16:0]        q;
        p   = 21'(d) * 21'($signed({1'b0, sens}));
        mag = p[20] ? 20'(-p) : 20'(p);
        sc  = (SCW'(mag) << AFB) + (SCW'(1) << (SFB - 1));
        q   = 17'(sc >> SFB);
        return p[20] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    state_t             state_reg;
    state_t             state_next;
    logic [9:0]         sensitivity_reg;
    logic signed [9:0]  delta_x_reg;
    logic signed [9:0]  delta_y_reg;
    logic signed [17:0] inc_x_reg;
    logic signed [17:0] inc_y_reg;
    logic signed [17:0] yaw_reg;
    logic signed [15:0] pitch_reg;
    cou_pkg::xval_t     cy_reg;
    cou_pkg::xval_t     sy_reg;
    cou_pkg::xval_t     cp_reg;
    cou_pkg::xval_t     sp_reg;
    logic               m_axis_tvalid_reg;
    logic [167:0]       m_axis_tdata_reg;

    logic signed [19:0] yaw_sum;
    logic signed [19:0] yaw_next;
    logic signed [19:0] pitch_sum;
    logic signed [19:0] pitch_next;
    logic signed [19:0] fold_ang;
    logic               fold_neg;
    logic               feed_valid;
    cou_pkg::cord_t     feed_data;
    cou_pkg::xval_t     end_cos;
    cou_pkg::xval_t     end_sin;
    logic               vec_done;
    cou_pkg::vec_t      vec;

    logic               cell_valid [0:CORDIC_STEPS];
    cou_pkg::cord_t     cell_data  [0:CORDIC_STEPS];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_axis_tvalid_reg;
    assign m_axis_tdata  = m_axis_tdata_reg;

    // yaw: sign-keeping remainder of 360 degrees; pitch: clamp to +-89
    always_comb
    begin
        yaw_sum = 20'(yaw_reg) + 20'(inc_x_reg);
        if (yaw_sum >= TWO_FULL_ANG)
            yaw_next = yaw_sum - TWO_FULL_ANG;
        else if (yaw_sum >= FULL_ANG)
            yaw_next = yaw_sum - FULL_ANG;
        else if (yaw_sum <= -TWO_FULL_ANG)
            yaw_next = yaw_sum + TWO_FULL_ANG;
        else if (yaw_sum <= -FULL_ANG)
            yaw_next = yaw_sum + FULL_ANG;
        else
            yaw_next = yaw_sum;

        pitch_sum = 20'(pitch_reg) + 20'(inc_y_reg);
        if (pitch_sum > PITCH_LIM)
            pitch_next = PITCH_LIM;
        else if (pitch_sum < -PITCH_LIM)
            pitch_next = -PITCH_LIM;
        else
            pitch_next = pitch_sum;
    end

    // fold the angle into +-90 degrees before it enters the chain
    always_comb
    begin
        fold_ang = (state_reg == S_FEED_PITCH) ? 20'(pitch_reg) : 20'(yaw_reg);
        if (fold_ang > HALF_ANG)
            fold_ang = fold_ang - FULL_ANG;
        else if (fold_ang <= -HALF_ANG)
            fold_ang = fold_ang + FULL_ANG;
        fold_neg = 1'b0;
        if (fold_ang > QUARTER_ANG)
        begin
            fold_ang = fold_ang - HALF_ANG;
            fold_neg = 1'b1;
        end
        else if (fold_ang < -QUARTER_ANG)
        begin
            fold_ang = fold_ang + HALF_ANG;
            fold_neg = 1'b1;
        end
        feed_valid         = (state_reg == S_FEED_YAW) || (state_reg == S_FEED_PITCH);
        feed_data.x        = cou_pkg::CORDIC_GAIN;
        feed_data.y        = '0;
        feed_data.z        = 33'(fold_ang) <<< SHIFTZ;
        feed_data.neg      = fold_neg;
        feed_data.is_pitch = (state_reg == S_FEED_PITCH);
    end

    assign cell_valid[0] = feed_valid;
    assign cell_data[0]  = feed_data;

    // the cordic chain, one rotation step per cell
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        cou_cell #(
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_valid[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    // undo the half-turn fold
    assign end_cos = cell_data[CORDIC_STEPS].neg ? -cell_data[CORDIC_STEPS].x
                                                 : cell_data[CORDIC_STEPS].x;
    assign end_sin = cell_data[CORDIC_STEPS].neg ? -cell_data[CORDIC_STEPS].y
                                                 : cell_data[CORDIC_STEPS].y;

    cou_vec u_vec (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_VEC_GO),
        .cy    (cy_reg),
        .sy    (sy_reg),
        .cp    (cp_reg),
        .sp    (sp_reg),
        .done  (vec_done),
        .vec   (vec)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (s_axis_tvalid)
                    state_next = S_SCALE;
            S_SCALE:      state_next = S_UPDATE;
            S_UPDATE:     state_next = S_FEED_YAW;
            S_FEED_YAW:   state_next = S_FEED_PITCH;
            S_FEED_PITCH: state_next = S_WAIT;
            S_WAIT:
                if (cell_valid[CORDIC_STEPS] && cell_data[CORDIC_STEPS].is_pitch)
                    state_next = S_VEC_GO;
            S_VEC_GO:     state_next = S_VEC_WAIT;
            S_VEC_WAIT:
                if (vec_done)
                    state_next = S_OUT;
            S_OUT:
                if (!m_axis_tvalid_reg || m_axis_tready)
                    state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            sensitivity_reg   <= cou_pkg::SENS_RESET;
            yaw_reg           <= 18'(-QUARTER_ANG);
            pitch_reg         <= '0;
            m_axis_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                sensitivity_reg <= cfg_wr_data;

            // result register: load a new item, or empty once taken
            if (state_reg == S_OUT && (!m_axis_tvalid_reg || m_axis_tready))
                m_axis_tvalid_reg <= 1'b1;
            else if (m_axis_tready)
                m_axis_tvalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    delta_x_reg <= $signed(s_axis_tdata[9:0]);
                    delta_y_reg <= $signed(s_axis_tdata[19:10]);
                end
                S_SCALE:
                begin
                    inc_x_reg <= scale_step(delta_x_reg, sensitivity_reg);
                    inc_y_reg <= scale_step(delta_y_reg, sensitivity_reg);
                end
                S_UPDATE:
                begin
                    yaw_reg   <= 18'(yaw_next);
                    pitch_reg <= 16'(pitch_next);
                end
                S_WAIT:
                begin
                    if (cell_valid[CORDIC_STEPS])
                    begin
                        if (cell_data[CORDIC_STEPS].is_pitch)
                        begin
                            cp_reg <= end_cos;
                            sp_reg <= end_sin;
                        end
                        else
                        begin
                            cy_reg <= end_cos;
                            sy_reg <= end_sin;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!m_axis_tvalid_reg || m_axis_tready)
                    begin
                        m_axis_tdata_reg  <= {6'b0, vec.up_z, vec.up_y, vec.up_x,
                                              vec.right_z, vec.right_x, vec.front_z,
                                              vec.front_y, vec.front_x, pitch_reg,
                                              yaw_reg};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // chain results only arrive while the sequencer waits for them
    a_chain_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[CORDIC_STEPS] |-> state_reg == S_WAIT)
        else $error("cordic result outside wait state");

    // vector unit finishes only while it is awaited
    a_vec_done: assert property (@(posedge clk) disable iff (!rst_n)
        vec_done |-> state_reg == S_VEC_WAIT)
        else $error("vector unit done out of turn");

    // pitch stays inside the clamp
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (20'(pitch_reg) <= PITCH_LIM) && (20'(pitch_reg) >= -PITCH_LIM))
        else $error("pitch outside +-89 degrees");

    // yaw stays strictly inside one turn
    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        (20'(yaw_reg) < FULL_ANG) && (20'(yaw_reg) > -FULL_ANG))
        else $error("yaw outside one turn");

endmodule

`default_nettype wire
